// ----- sv/bmpq_pkg.sv -----
// Package: sizes, codes, node record types and sequencer states of the binomial max queue.
`default_nettype none
package bmpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int MAX_ORDER = 11;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int PTR_W     = IDX_W + 1;
    localparam int ORD_W     = 4;
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 16;
    localparam int SLOT_W    = $clog2(MAX_ORDER);
    localparam int SP_W      = $clog2(MAX_ORDER + 1);

    localparam logic [PTR_W-1:0]  NIL      = PTR_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(MAX_ORDER - 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_FIND   = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       data;
        logic [ORD_W-1:0]        order;
        logic [PTR_W-1:0]        fc;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_rec             rec;
    } t_node;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_RD,
        S_MAX_RD,
        S_CH_RD,
        S_CH_LD,
        S_A_RD,
        S_A_LD,
        S_PICK,
        S_LINK,
        S_FIN,
        S_FLUSH,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- sv/bmpq_intf.sv -----
// Interfaces: command item channel and result item channel.
`default_nettype none
interface bmpq_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic signed [31:0] key;
    logic [15:0]       payload;

    modport source (output valid, output action, output key, output payload, input ready);
    modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

interface bmpq_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_payload;
    logic [1:0]  status;

    modport source (output valid, output result_payload, output status, input ready);
    modport sink   (input valid, input result_payload, input status, output ready);
endinterface
`default_nettype wire

// ----- sv/bmpq_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
`default_nettype none
module bmpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- sv/binomial_max_priority_queue_top.sv -----
// Top level: binomial-heap max priority queue with node pool in RAM.
//
//  channel   dir  fields                          accepted when
//  i_item    in   action, key, payload            valid && ready
//  o_result  out  result_payload, status          valid && ready
//
// After reset a sweep over all CAPACITY (1024) entries builds the free chain in
// the sibling RAM; no item is taken during it.
// One item at a time. Find reads the root record and returns its payload.
// Insert and remove read each root (and, for remove, each child of the
// removed root), store each tree in a degree slot, linking it with every
// tree of equal order, then pass over the MAX_ORDER slots for the head;
// the pace is bound by the single read port of the node RAMs. A finished
// result waits in the output register while the next item is taken.
`default_nettype none
module binomial_max_priority_queue_top
    import bmpq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmpq_in_if.sink    i_item,
    bmpq_out_if.source o_result
);

    // sequencer
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_init_idx, n_init_idx;

    // latched command
    logic [1:0]              r_act, n_act;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic [DATA_W-1:0]       r_pay, n_pay;

    // queue bookkeeping
    logic [PTR_W-1:0] r_root, n_root;
    logic [PTR_W-1:0] r_free, n_free;
    logic [PTR_W-1:0] r_count, n_count;

    // pending result and output register
    logic [DATA_W-1:0] r_res_pay, n_res_pay;
    logic [1:0]        r_res_stat, n_res_stat;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_pay, n_out_pay;
    logic [1:0]        r_out_stat, n_out_stat;

    // stream A: main root list, one node cached
    logic [PTR_W-1:0] r_a_ptr, n_a_ptr;
    logic             r_a_has, n_a_has;
    t_node            r_a, n_a;

    // stream B: child list of the removed root (or the new node), as a stack
    logic [PTR_W-1:0] r_child, n_child;
    t_node            r_stk [MAX_ORDER];
    t_node            n_stk [MAX_ORDER];
    logic [SP_W-1:0]  r_sp, n_sp;

    // consolidation
    t_node             r_walk, n_walk;
    logic              r_refill_a, n_refill_a;
    logic [SLOT_W-1:0] r_d, n_d;
    logic [MAX_ORDER-1:0] r_slot_v, n_slot_v;
    t_node             r_slot [MAX_ORDER];
    t_node             n_slot [MAX_ORDER];

    // head selection pass
    logic [SLOT_W-1:0]       r_i, n_i;
    logic                    r_h_has, n_h_has;
    logic [IDX_W-1:0]        r_h, n_h;
    logic signed [KEY_W-1:0] r_h_key, n_h_key;
    logic [PTR_W-1:0]        r_hn, n_hn;

    // RAM ports
    logic             rec_we, sib_we;
    logic [IDX_W-1:0] rec_waddr, sib_waddr, rd_addr;
    logic [REC_W-1:0] rec_wdata, rec_rdata;
    logic [PTR_W-1:0] sib_wdata, sib_rd;
    t_rec             rec_rd;

    bmpq_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rec_rdata)
    );

    bmpq_ram #(.WIDTH(PTR_W), .DEPTH(CAPACITY)) u_sib_ram (
        .i_clk   (i_clk),
        .i_we    (sib_we),
        .i_waddr (sib_waddr),
        .i_wdata (sib_wdata),
        .i_raddr (rd_addr),
        .o_rdata (sib_rd)
    );

    assign rec_rd = t_rec'(rec_rdata);

    function automatic logic [SLOT_W-1:0] slot_of(input logic [ORD_W-1:0] ord);
        logic [SLOT_W-1:0] s;
        s = SLOT_TOP;
        if (int'(ord) < MAX_ORDER - 1) begin
            s = SLOT_W'(ord);
        end
        return s;
    endfunction

    // shared decisions
    logic              accept, is_full, b_has, pick_a, slot_cur_v, walk_top, t_gt;
    logic [SP_W-1:0]   sp_m1;
    t_node             stk_top, picked, slot_cur, top_n, sub_n, new_walk;
    logic [SLOT_W-1:0] slot_sel, d_next;

    assign accept   = i_item.valid && (r_state == S_IDLE);
    assign is_full  = (r_count >= PTR_W'(CAPACITY)) || (r_free == NIL);
    assign sp_m1    = r_sp - SP_W'(1);
    assign stk_top  = r_stk[sp_m1[SLOT_W-1:0]];
    assign b_has    = (r_sp != '0);
    // ties on order go to the main list
    assign pick_a   = r_a_has && (!b_has || (r_a.rec.order <= stk_top.rec.order));
    assign picked   = pick_a ? r_a : stk_top;
    assign slot_sel = (r_state == S_FIN) ? r_i : r_d;
    assign slot_cur = r_slot[slot_sel];
    assign slot_cur_v = r_slot_v[slot_sel];
    // walker keeps the root on equal keys
    assign walk_top = !(r_walk.rec.key < slot_cur.rec.key);
    assign top_n    = walk_top ? r_walk : slot_cur;
    assign sub_n    = walk_top ? slot_cur : r_walk;
    assign d_next   = (r_d < SLOT_TOP) ? (r_d + SLOT_W'(1)) : r_d;
    assign t_gt     = !r_h_has || (slot_cur.rec.key > r_h_key);

    always_comb begin
        new_walk           = top_n;
        new_walk.rec.fc    = {1'b0, sub_n.idx};
        new_walk.rec.order = top_n.rec.order + ORD_W'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_init_idx == IDX_W'(CAPACITY - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_item.valid) begin
                    case (i_item.action)
                        ACT_INSERT: n_state = is_full ? S_DONE : S_INS_RD;
                        ACT_FIND, ACT_REMOVE: n_state = (r_root == NIL) ? S_DONE : S_MAX_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD: n_state = S_A_RD;
            S_MAX_RD: n_state = (r_act == ACT_REMOVE) ? S_CH_RD : S_DONE;
            S_CH_RD:  n_state = (r_child == NIL) ? S_A_RD : S_CH_LD;
            S_CH_LD:  n_state = S_CH_RD;
            S_A_RD:   n_state = (r_a_ptr == NIL) ? S_PICK : S_A_LD;
            S_A_LD:   n_state = S_PICK;
            S_PICK:   n_state = (!r_a_has && !b_has) ? S_FIN : S_LINK;
            S_LINK: begin
                if (!slot_cur_v) n_state = r_refill_a ? S_A_RD : S_PICK;
            end
            S_FIN: begin
                if (r_i == SLOT_TOP) n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || o_result.ready) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // datapath and RAM controls
    always_comb begin
        n_init_idx = r_init_idx;
        n_act      = r_act;
        n_key      = r_key;
        n_pay      = r_pay;
        n_root     = r_root;
        n_free     = r_free;
        n_count    = r_count;
        n_res_pay  = r_res_pay;
        n_res_stat = r_res_stat;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_pay  = r_out_pay;
        n_out_stat = r_out_stat;
        n_a_ptr    = r_a_ptr;
        n_a_has    = r_a_has;
        n_a        = r_a;
        n_child    = r_child;
        n_stk      = r_stk;
        n_sp       = r_sp;
        n_walk     = r_walk;
        n_refill_a = r_refill_a;
        n_d        = r_d;
        n_slot_v   = r_slot_v;
        n_slot     = r_slot;
        n_i        = r_i;
        n_h_has    = r_h_has;
        n_h        = r_h;
        n_h_key    = r_h_key;
        n_hn       = r_hn;

        rec_we    = 1'b0;
        rec_waddr = '0;
        rec_wdata = '0;
        sib_we    = 1'b0;
        sib_waddr = '0;
        sib_wdata = '0;
        rd_addr   = r_a_ptr[IDX_W-1:0];

        case (r_state)
            S_INIT: begin
                sib_we     = 1'b1;
                sib_waddr  = r_init_idx;
                sib_wdata  = {1'b0, r_init_idx} + PTR_W'(1);
                n_init_idx = r_init_idx + IDX_W'(1);
            end
            S_IDLE: begin
                rd_addr = (i_item.action == ACT_INSERT) ? r_free[IDX_W-1:0]
                                                        : r_root[IDX_W-1:0];
                if (accept) begin
                    n_act      = i_item.action;
                    n_key      = i_item.key;
                    n_pay      = i_item.payload;
                    n_res_pay  = '0;
                    n_res_stat = STAT_OK;
                    n_sp       = '0;
                    case (i_item.action)
                        ACT_INSERT: begin
                            if (is_full) n_res_stat = STAT_FULL;
                        end
                        ACT_FIND, ACT_REMOVE: begin
                            if (r_root == NIL) n_res_stat = STAT_EMPTY;
                        end
                        default: n_res_stat = STAT_OK;
                    endcase
                end
            end
            S_INS_RD: begin
                n_free             = sib_rd;
                n_count            = r_count + PTR_W'(1);
                n_stk[0].idx       = r_free[IDX_W-1:0];
                n_stk[0].rec.key   = r_key;
                n_stk[0].rec.data  = r_pay;
                n_stk[0].rec.order = '0;
                n_stk[0].rec.fc    = NIL;
                n_sp               = SP_W'(1);
                n_a_ptr            = r_root;
            end
            S_MAX_RD: begin
                n_res_pay = rec_rd.data;
                if (r_act == ACT_REMOVE) begin
                    n_a_ptr   = sib_rd;
                    n_child   = rec_rd.fc;
                    sib_we    = 1'b1;
                    sib_waddr = r_root[IDX_W-1:0];
                    sib_wdata = r_free;
                    n_free    = r_root;
                    if (r_count != '0) n_count = r_count - PTR_W'(1);
                end
            end
            S_CH_RD: begin
                rd_addr = r_child[IDX_W-1:0];
            end
            S_CH_LD: begin
                // children come highest order first; the stack pops lowest first
                n_stk[r_sp[SLOT_W-1:0]].idx = r_child[IDX_W-1:0];
                n_stk[r_sp[SLOT_W-1:0]].rec = rec_rd;
                n_sp    = r_sp + SP_W'(1);
                n_child = sib_rd;
            end
            S_A_RD: begin
                rd_addr = r_a_ptr[IDX_W-1:0];
                if (r_a_ptr == NIL) n_a_has = 1'b0;
            end
            S_A_LD: begin
                n_a.idx = r_a_ptr[IDX_W-1:0];
                n_a.rec = rec_rd;
                n_a_has = 1'b1;
                n_a_ptr = sib_rd;
            end
            S_PICK: begin
                if (r_a_has || b_has) begin
                    n_walk     = picked;
                    n_d        = slot_of(picked.rec.order);
                    n_refill_a = pick_a;
                    if (pick_a) n_a_has = 1'b0;
                    else        n_sp    = sp_m1;
                end else begin
                    n_i     = '0;
                    n_h_has = 1'b0;
                    n_hn    = NIL;
                end
            end
            S_LINK: begin
                if (slot_cur_v) begin
                    // the losing tree is final: write it back
                    rec_we    = 1'b1;
                    rec_waddr = sub_n.idx;
                    rec_wdata = sub_n.rec;
                    sib_we    = 1'b1;
                    sib_waddr = sub_n.idx;
                    sib_wdata = top_n.rec.fc;
                    n_walk    = new_walk;
                    n_slot_v[r_d] = 1'b0;
                    n_d       = d_next;
                end else begin
                    n_slot[r_d]   = r_walk;
                    n_slot_v[r_d] = 1'b1;
                end
            end
            S_FIN: begin
                if (slot_cur_v) begin
                    rec_we    = 1'b1;
                    rec_waddr = slot_cur.idx;
                    rec_wdata = slot_cur.rec;
                    n_slot_v[r_i] = 1'b0;
                    if (t_gt) begin
                        // new head; old head gets its deferred sibling
                        sib_we    = r_h_has;
                        sib_waddr = r_h;
                        sib_wdata = r_hn;
                        n_hn      = r_h_has ? {1'b0, r_h} : NIL;
                        n_h       = slot_cur.idx;
                        n_h_key   = slot_cur.rec.key;
                        n_h_has   = 1'b1;
                    end else begin
                        sib_we    = 1'b1;
                        sib_waddr = slot_cur.idx;
                        sib_wdata = r_hn;
                        n_hn      = {1'b0, slot_cur.idx};
                    end
                end
                if (r_i != SLOT_TOP) n_i = r_i + SLOT_W'(1);
            end
            S_FLUSH: begin
                sib_we    = r_h_has;
                sib_waddr = r_h;
                sib_wdata = r_hn;
                n_root    = r_h_has ? {1'b0, r_h} : NIL;
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_pay   = r_res_pay;
                    n_out_stat  = r_res_stat;
                end
            end
            default: begin
                n_init_idx = r_init_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_idx  <= '0;
            r_root      <= NIL;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_a_has     <= 1'b0;
            r_sp        <= '0;
            r_slot_v    <= '0;
            r_h_has     <= 1'b0;
            r_refill_a  <= 1'b0;
            r_d         <= '0;
            r_i         <= '0;
            r_act       <= ACT_INSERT;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_root      <= n_root;
            r_free      <= n_free;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_a_has     <= n_a_has;
            r_sp        <= n_sp;
            r_slot_v    <= n_slot_v;
            r_h_has     <= n_h_has;
            r_refill_a  <= n_refill_a;
            r_d         <= n_d;
            r_i         <= n_i;
            r_act       <= n_act;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_res_pay  <= n_res_pay;
        r_res_stat <= n_res_stat;
        r_out_pay  <= n_out_pay;
        r_out_stat <= n_out_stat;
        r_a_ptr    <= n_a_ptr;
        r_a        <= n_a;
        r_child    <= n_child;
        r_stk      <= n_stk;
        r_walk     <= n_walk;
        r_slot     <= n_slot;
        r_h        <= n_h;
        r_h_key    <= n_h_key;
        r_hn       <= n_hn;
    end

    assign i_item.ready            = (r_state == S_IDLE);
    assign o_result.valid          = r_out_valid;
    assign o_result.result_payload = r_out_pay;
    assign o_result.status         = r_out_stat;

    // degree slots are all drained by the head pass
    a_slots_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_slot_v == '0))
        else $error("degree slot left occupied");

    // empty root list exactly when no entries are held
    a_root_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_root == NIL) == (r_count == '0)))
        else $error("root list and entry count disagree");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PTR_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // child stack has room for every child of a binomial tree
    a_stack_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CH_LD) |-> (r_sp < SP_W'(MAX_ORDER)))
        else $error("child stack overflow");

endmodule
`default_nettype wire
